// ----- design/mst_pkg.sv -----
// Package for the max-subarray segment tree: node type, join function,
// FSM states and tree sizing constants. No dependencies.
package mst_pkg;

  localparam int LEAF_COUNT = 1024;
  localparam int LEAF_BITS  = $clog2(LEAF_COUNT);
  localparam int VALUE_BITS = 16;
  localparam int POS_BITS   = 10;
  localparam int LEN_BITS   = 11;
  localparam int SUM_BITS   = VALUE_BITS + LEAF_BITS + 1;
  localparam int OUT_BITS   = 26;
  localparam int NODE_AW    = LEAF_BITS + 1;          // heap address, root at 1
  localparam int NODE_DEPTH = 2 * LEAF_COUNT;
  localparam int IDX_W      = LEAF_BITS + 2;          // walk index, room for +1

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] total;
    logic signed [SUM_BITS-1:0] pre;
    logic signed [SUM_BITS-1:0] suf;
    logic signed [SUM_BITS-1:0] best;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_WRITE,
    ST_W_JOIN,
    ST_Q_LCHK,
    ST_Q_LJOIN,
    ST_Q_RCHK,
    ST_Q_RJOIN,
    ST_Q_DONE
  } state_t;

  function automatic logic signed [SUM_BITS-1:0] smax(input logic signed [SUM_BITS-1:0] a,
                                                      input logic signed [SUM_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // a covers the span left of b
  function automatic node_t join_nodes(input node_t a, input node_t b);
    node_t s;
    s.total = a.total + b.total;
    s.pre   = smax(a.pre, a.total + b.pre);
    s.suf   = smax(b.suf, b.total + a.suf);
    s.best  = smax(smax(a.best, b.best), a.suf + b.pre);
    return s;
  endfunction

endpackage

// ----- design/mst_ifs.sv -----
// Handshake channel interfaces for the segment tree block.
// Depends on mst_pkg.
interface mst_in_if import mst_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [POS_BITS-1:0]         write_position;
  logic signed [VALUE_BITS-1:0] new_value;
  logic [POS_BITS-1:0]         range_left;
  logic [POS_BITS-1:0]         range_right;
  modport source (output valid, opcode, write_position, new_value, range_left, range_right,
                  input ready);
  modport sink (input valid, opcode, write_position, new_value, range_left, range_right,
                output ready);
endinterface

interface mst_out_if import mst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] best_sum;
  logic                       range_error;
  modport source (output valid, best_sum, range_error, input ready);
  modport sink (input valid, best_sum, range_error, output ready);
endinterface

interface mst_cfg_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/mst_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/max_subarray_segment_tree.sv -----
// Max-subarray segment tree top level. Depends on mst_pkg, mst_ifs, mst_ram.
// Write: stores the leaf, then per level reads the sibling and stores the joined parent
//   up to the root; query: two reads per tree level on the single node RAM read port.
// Throughput: one transaction at a time; the result register frees the input side.
// Reset: synchronous active-low; afterwards a clearing pass writes zero to all 2048
//   node RAM entries while in.ready stays low. active_length resets to 1024.
module max_subarray_segment_tree
  import mst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mst_in_if.sink    in_bus,
  mst_out_if.source out_bus,
  mst_cfg_if.sink   cfg_bus
);

  state_t state_r, state_nxt;

  logic [LEN_BITS-1:0] alen_r;
  logic [NODE_AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  // Bottom-up walk: left and right cursors with their partial results.
  logic [IDX_W-1:0] idx_l_r, idx_l_nxt, idx_r_r, idx_r_nxt;
  node_t            acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic             has_l_r, has_l_nxt, has_r_r, has_r_nxt;
  logic             err_r, err_nxt;

  // Result register
  logic                       out_valid_r;
  logic signed [OUT_BITS-1:0] out_sum_r;
  logic                       out_err_r;
  logic                       out_load;
  logic signed [OUT_BITS-1:0] out_sum_nxt;

  // Node RAM port
  logic               ram_we;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  node_t              ram_wdata, ram_rdata;

  node_t leaf_node, final_node;

  mst_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= LEN_BITS'(LEAF_COUNT);
    end else if (cfg_bus.valid) begin
      alen_r <= cfg_bus.data;
    end
  end

  assign in_bus.ready    = (state_r == ST_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.best_sum    = out_sum_r;
  assign out_bus.range_error = out_err_r;

  always_comb begin
    leaf_node.total = SUM_BITS'(in_bus.new_value);
    leaf_node.pre   = SUM_BITS'(in_bus.new_value);
    leaf_node.suf   = SUM_BITS'(in_bus.new_value);
    leaf_node.best  = SUM_BITS'(in_bus.new_value);
    // merge the two partial results; at least one is present unless the range is in error
    if (has_l_r && has_r_r) begin
      final_node = join_nodes(acc_l_r, acc_r_r);
    end else if (has_l_r) begin
      final_node = acc_l_r;
    end else begin
      final_node = acc_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_l_r <= idx_l_nxt;
    idx_r_r <= idx_r_nxt;
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    has_l_r <= has_l_nxt;
    has_r_r <= has_r_nxt;
    err_r   <= err_nxt;
    if (out_load) begin
      out_sum_r <= out_sum_nxt;
      out_err_r <= err_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    idx_l_nxt   = idx_l_r;
    idx_r_nxt   = idx_r_r;
    acc_l_nxt   = acc_l_r;
    acc_r_nxt   = acc_r_r;
    has_l_nxt   = has_l_r;
    has_r_nxt   = has_r_r;
    err_nxt     = err_r;
    out_load    = 1'b0;
    out_sum_nxt = err_r ? '0 : final_node.best[OUT_BITS-1:0];
    ram_we      = 1'b0;
    ram_waddr   = idx_l_r[NODE_AW-1:0];
    ram_wdata   = acc_l_r;
    ram_raddr   = idx_l_r[NODE_AW-1:0];

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == NODE_AW'(NODE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_bus.valid) begin
          if (in_bus.opcode == OP_WRITE) begin
            idx_l_nxt = IDX_W'(LEAF_COUNT) + IDX_W'(in_bus.write_position);
            acc_l_nxt = leaf_node;
            if (IDX_W'(in_bus.write_position) < IDX_W'(LEAF_COUNT)) begin
              state_nxt = ST_W_WRITE;
            end
          end else begin
            idx_l_nxt = IDX_W'(LEAF_COUNT) + IDX_W'(in_bus.range_left);
            idx_r_nxt = IDX_W'(LEAF_COUNT) + IDX_W'(in_bus.range_right);
            has_l_nxt = 1'b0;
            has_r_nxt = 1'b0;
            err_nxt   = (in_bus.range_left > in_bus.range_right) ||
                        (LEN_BITS'(in_bus.range_right) >= alen_r) ||
                        (IDX_W'(in_bus.range_right) >= IDX_W'(LEAF_COUNT));
            state_nxt = err_nxt ? ST_Q_DONE : ST_Q_LCHK;
          end
        end
      end
      ST_W_WRITE: begin
        ram_we = 1'b1;
        if (idx_l_r == IDX_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_raddr = idx_l_r[NODE_AW-1:0] ^ NODE_AW'(1);   // sibling
          state_nxt = ST_W_JOIN;
        end
      end
      ST_W_JOIN: begin
        acc_l_nxt = idx_l_r[0] ? join_nodes(ram_rdata, acc_l_r)
                               : join_nodes(acc_l_r, ram_rdata);
        idx_l_nxt = idx_l_r >> 1;
        state_nxt = ST_W_WRITE;
      end
      ST_Q_LCHK: begin
        if (idx_l_r > idx_r_r) begin
          state_nxt = ST_Q_DONE;
        end else if (idx_l_r[0]) begin
          state_nxt = ST_Q_LJOIN;
        end else begin
          state_nxt = ST_Q_RCHK;
        end
      end
      ST_Q_LJOIN: begin
        acc_l_nxt = has_l_r ? join_nodes(acc_l_r, ram_rdata) : ram_rdata;
        has_l_nxt = 1'b1;
        idx_l_nxt = idx_l_r + 1'b1;
        state_nxt = ST_Q_RCHK;
      end
      ST_Q_RCHK: begin
        ram_raddr = idx_r_r[NODE_AW-1:0];
        if (idx_l_r <= idx_r_r && !idx_r_r[0]) begin
          state_nxt = ST_Q_RJOIN;
        end else begin
          idx_l_nxt = idx_l_r >> 1;
          idx_r_nxt = idx_r_r >> 1;
          state_nxt = ST_Q_LCHK;
        end
      end
      ST_Q_RJOIN: begin
        acc_r_nxt = has_r_r ? join_nodes(ram_rdata, acc_r_r) : ram_rdata;
        has_r_nxt = 1'b1;
        idx_l_nxt = idx_l_r >> 1;
        idx_r_nxt = (idx_r_r - 1'b1) >> 1;
        state_nxt = ST_Q_LCHK;
      end
      ST_Q_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mst_checker.sv -----
// Port-level checker for the segment tree block, bound to the top level.
// Depends on mst_pkg for widths.
module mst_checker
  import mst_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] out_best_sum,
  input logic                out_range_error
);

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_sum))
    else $error("result changed while stalled");

  // error results carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_best_sum == '0)
    else $error("error result with nonzero sum");

  // an accepted transaction keeps the input closed on the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transaction");

  // clearing pass keeps input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing");

  // no result right after reset
  a_no_out_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind max_subarray_segment_tree mst_checker u_mst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_best_sum    (out_bus.best_sum),
  .out_range_error (out_bus.range_error)
);

// ----- verif/max_subarray_segment_tree_tb.sv -----
// Testbench for max_subarray_segment_tree: directed and random writes and range
// queries checked against a behavioral linear-scan predictor in a scoreboard class.
// Depends on mst_pkg and the mst_ifs channel interfaces.
`timescale 1ns / 100ps
module max_subarray_segment_tree_tb;
  import mst_pkg::*;

  localparam int IDLE_TAIL   = 4 * LEAF_BITS + 16;  // worst query latency plus margin
  localparam int STALL_LIMIT = 20000;               // covers the clear pass
  localparam int RAND_ITEMS  = 1830;

  logic clk;
  logic rst_n;

  mst_in_if  in_bus ();
  mst_out_if out_bus ();
  mst_cfg_if cfg_bus ();

  max_subarray_segment_tree i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_bus (cfg_bus.sink)
  );

  // Scoreboard: holds a flat copy of the element array plus active_length,
  // predicts each query by a linear max-subarray scan (a different algorithm
  // than the tree, so the two cross-check), and queues the expected results.
  class range_sum_board;
    logic signed [VALUE_BITS-1:0] elems [LEAF_COUNT];
    logic [LEN_BITS-1:0]          act_len;
    logic signed [OUT_BITS-1:0]   sum_q [$];
    logic                         err_q [$];
    int                           errors;

    function void clear();
      foreach (elems[i]) elems[i] = '0;
      act_len = 11'd1024;
      errors  = 0;
    endfunction

    // Writes update the copy; queries run Kadane over [l, r]; bad ranges give error and zero
    function void note_item(logic op, logic [POS_BITS-1:0] pos, logic signed [VALUE_BITS-1:0] val,
                            logic [POS_BITS-1:0] l, logic [POS_BITS-1:0] r);
      longint run;
      longint top;
      if (op == OP_WRITE) begin
        elems[pos] = val;
        return;
      end
      if (l > r || {1'b0, r} >= act_len) begin
        sum_q.push_back('0);
        err_q.push_back(1'b1);
        return;
      end
      run = elems[l];
      top = run;
      for (int i = l + 1; i <= r; i++) begin
        run = (run > 0) ? run + elems[i] : longint'(elems[i]);
        if (run > top) top = run;
      end
      sum_q.push_back(top[OUT_BITS-1:0]);
      err_q.push_back(1'b0);
    endfunction

    function void check_result(logic signed [OUT_BITS-1:0] got_sum, logic got_err);
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected result best_sum=%0d range_error=%0b", $time, got_sum, got_err);
        errors++;
        return;
      end
      if (got_sum !== sum_q[0] || got_err !== err_q[0]) begin
        $display("%0t: mismatch expected best_sum=%0d range_error=%0b, actual best_sum=%0d range_error=%0b",
                 $time, sum_q[0], err_q[0], got_sum, got_err);
        errors++;
      end
      void'(sum_q.pop_front());
      void'(err_q.pop_front());
    endfunction
  endclass

  range_sum_board board;
  bit   idling_on;
  int   stall_cnt;
  bit   timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: sample on the rising edge, change ready on the falling one.
  initial begin
    int burst;
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_bus.ready = 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        board.check_result(out_bus.best_sum, out_bus.range_error);
      @(negedge clk);
    end
  end

  // Watchdog: any cycle without a transaction on any channel counts toward the limit.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
  end

  always @(posedge clk) begin
    if (stall_cnt >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("max_subarray_segment_tree regression: fail");
      $finish;
    end
  end

  // One input transaction; optional random gap first. Called at a falling edge.
  task automatic send_item(logic op, logic [POS_BITS-1:0] pos, logic signed [VALUE_BITS-1:0] val,
                           logic [POS_BITS-1:0] l, logic [POS_BITS-1:0] r);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_bus.valid          = 1'b1;
    in_bus.opcode         = op;
    in_bus.write_position = pos;
    in_bus.new_value      = val;
    in_bus.range_left     = l;
    in_bus.range_right    = r;
    do @(posedge clk); while (!in_bus.ready);
    board.note_item(op, pos, val, l, r);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic do_write(int pos, int val);
    send_item(OP_WRITE, pos[POS_BITS-1:0], val[VALUE_BITS-1:0], '0, '0);
  endtask

  task automatic do_query(int l, int r);
    send_item(OP_QUERY, POS_BITS'($urandom), VALUE_BITS'($urandom),
              l[POS_BITS-1:0], r[POS_BITS-1:0]);
  endtask

  // Drain outstanding results, then let the block settle before a register write.
  task automatic drain();
    while (board.sum_q.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic set_length(int len);
    drain();
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = len[LEN_BITS-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    board.act_len = len[LEN_BITS-1:0];
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Random value: small mixed-sign half the time, else an extreme or any 16-bit value.
  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // Random query inside [0, span), occasionally reversed or past the end.
  task automatic rand_query(int span);
    int l;
    int r;
    l = $urandom_range(0, span - 1);
    r = $urandom_range(l, (l + 40 < span) ? l + 40 : span - 1);
    case ($urandom_range(0, 9))
      0: do_query(r, l);                        // reversed when l != r
      1: do_query($urandom_range(0, 1023), $urandom_range(0, 1023));
      2: do_query(0, span - 1);
      default: do_query(l, r);
    endcase
  endtask

  initial begin
    int lens [6] = '{1024, 1, 17, 2047, 0, 300};
    int n;
    board = new();
    board.clear();
    idling_on = 1'b1;
    timed_out = 1'b0;
    stall_cnt = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_WRITE;
    in_bus.write_position = '0;
    in_bus.new_value = '0;
    in_bus.range_left = '0;
    in_bus.range_right = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: all-zero tree, extremes of values and indices, bad ranges.
    do_query(0, 1023);
    do_query(5, 5);
    do_write(0, -32768);
    do_write(1023, 32767);
    do_write(1, 32767);
    do_write(2, -32768);
    do_write(3, -1);
    do_query(0, 0);
    do_query(0, 3);
    do_query(1023, 1023);
    do_query(0, 1023);
    do_query(3, 2);
    do_query(1023, 0);
    do_write(512, 21845);
    do_write(511, -21846);
    do_query(500, 520);
    do_query(2, 3);
    // all-negative span: best is the single largest element
    do_write(10, -5);
    do_write(11, -3);
    do_write(12, -9);
    do_query(10, 12);
    // sender waits for everything to come back
    while (board.sum_q.size() != 0) @(negedge clk);
    do_query(0, 1023);

    // Register sweep: zero length, one, above LEAF_COUNT.
    set_length(0);
    do_query(0, 0);
    do_query(5, 900);
    set_length(1);
    do_query(0, 0);
    do_query(0, 1);
    do_write(700, 1234);                        // stored past the active length
    set_length(2047);
    do_query(690, 710);
    do_query(0, 1023);

    // Random: phases of different active lengths, mostly writes/queries near the front.
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      set_length(lens[ph]);
      if (ph == 5) idling_on = 1'b0;            // final stretch without idling
      repeat (RAND_ITEMS / 6) begin
        int span;
        span = (lens[ph] == 0) ? 64 : ((lens[ph] > 1024) ? 1024 : lens[ph]);
        if ($urandom_range(0, 15) == 0) span = 1024;
        if ($urandom_range(0, 1) == 0)
          do_write($urandom_range(0, span - 1), rand_value());
        else
          rand_query(span);
        n++;
      end
    end

    while (board.sum_q.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
    if (board.errors == 0)
      $display("max_subarray_segment_tree regression: pass");
    else
      $display("max_subarray_segment_tree regression: fail");
    $finish;
  end

endmodule
